// ----- src/rw_queue_addr_map_hazard_top_macros.svh -----
// assertion macros shared by the read/write queue front end
`ifndef RW_QUEUE_ADDR_MAP_HAZARD_TOP_MACROS_SVH
`define RW_QUEUE_ADDR_MAP_HAZARD_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define RWQ_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("rwq check failed");
`define RWQ_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("rwq check failed");
`else
`define RWQ_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define RWQ_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif

`endif

// ----- src/rwq_pkg.sv -----
// shared types, constants and address split for the read/write queue front end
`default_nettype none

package rwq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int ADDR_BITS   = 40;
    localparam int TAG_BITS    = 8;

    localparam int IN_BITS     = 2 * (1 + ADDR_BITS + TAG_BITS + 1) + 2;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 43;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_READ   = 2'd1,
        KIND_WRITE  = 2'd2
    } t_kind;

    typedef enum logic {
        REQ_ADD      = 1'b0,
        REQ_DISPATCH = 1'b1
    } t_req;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [TAG_BITS-1:0]  tag;
        logic                 to_cache;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    // first field sits in the lowest bits, so it is listed last here
    typedef struct packed {
        logic                 wr_taken;
        logic                 rd_taken;
        logic                 wr_to_cache;
        logic [TAG_BITS-1:0]  wr_token;
        logic [ADDR_BITS-1:0] wr_addr;
        logic                 wr_valid;
        logic                 rd_to_cache;
        logic [TAG_BITS-1:0]  rd_token;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 rd_valid;
    } t_in_data;

    typedef struct packed {
        logic       all_empty;
        logic [9:0] out_column;
        logic [1:0] out_group;
        logic [1:0] out_bank;
        logic [15:0] out_row;
        logic       out_rank;
        logic       out_to_cache;
        logic [7:0] out_token;
        logic       write_accepted;
        logic       read_accepted;
    } t_out_data;

    typedef struct packed {
        t_kind     kind;
        logic      last;
        t_out_data data;
    } t_result;

    // split a queue entry into rank, row, bank, bank group and column, keeping its token and cache flag
    function automatic t_out_data map_entry(input t_entry e);
        t_out_data d;
        d                = '0;
        d.out_token      = 8'(e.tag);
        d.out_to_cache   = e.to_cache;
        d.out_rank       = e.addr[33];
        d.out_row        = e.addr[32:17];
        d.out_bank       = e.addr[16:15];
        d.out_group      = e.addr[7:6];
        d.out_column     = {e.addr[14:8], e.addr[5:3]};
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- src/rwq_cell.sv -----
// one queue slot: holds an entry, shifts toward the head on pop, compares its address
`default_nettype none

module rwq_cell
    import rwq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic                 i_prev_valid,
    input  wire t_entry               i_new,
    input  wire logic                 i_nxt_valid,
    input  wire t_entry               i_nxt,
    input  wire logic [ADDR_BITS-1:0] i_cmp_addr,
    output logic                      o_valid,
    output t_entry                    o_entry,
    output logic                      o_match
);

    logic   r_valid;
    t_entry r_entry;
    logic   n_valid;
    t_entry n_entry;
    logic   w_load;

    // the first empty slot behind an occupied one takes the pushed entry
    assign w_load = i_ctl.push && i_prev_valid && !r_valid;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.pop) begin
            n_valid = i_nxt_valid;
            n_entry = i_nxt;
        end else if (w_load) begin
            n_valid = 1'b1;
            n_entry = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_match = r_valid && (r_entry.addr == i_cmp_addr);

endmodule

`default_nettype wire

// ----- src/rwq_queue.sv -----
// shifting queue built from a row of slots, head in slot zero
`default_nettype none
`include "rw_queue_addr_map_hazard_top_macros.svh"

module rwq_queue
    import rwq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctl            i_ctl,
    input  wire t_entry               i_new,
    input  wire logic [ADDR_BITS-1:0] i_cmp_addr,
    output t_entry                    o_head,
    output logic                      o_empty,
    output logic                      o_full,
    output logic                      o_one,
    output logic                      o_match
);

    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_match;
    t_entry                 w_entry [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH:0]   w_valid_up;
    logic [QUEUE_DEPTH-1:0] w_valid_dn;

    // neighbor views: slot above for shifting, slot below for push position
    assign w_valid_up           = {1'b0, w_valid};
    assign w_valid_dn           = {w_valid[QUEUE_DEPTH-2:0], 1'b1};
    assign w_entry[QUEUE_DEPTH] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        rwq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_prev_valid (w_valid_dn[g]),
            .i_new        (i_new),
            .i_nxt_valid  (w_valid_up[g+1]),
            .i_nxt        (w_entry[g+1]),
            .i_cmp_addr   (i_cmp_addr),
            .o_valid      (w_valid[g]),
            .o_entry      (w_entry[g]),
            .o_match      (w_match[g])
        );
    end

    assign o_head  = w_entry[0];
    assign o_empty = !w_valid[0];
    assign o_full  = w_valid[QUEUE_DEPTH-1];
    assign o_one   = w_valid_up[0] && !w_valid_up[1];
    assign o_match = |w_match;

    // occupied slots always form an unbroken run from the head
    `RWQ_ASSERT_IMP(a_packed_run, i_clk, i_rst_n, 1'b1,
        ((w_valid + 1'b1) & w_valid) == '0)
    `RWQ_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_ctl.push, !o_full)
    `RWQ_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, i_ctl.push && !i_ctl.pop, !o_empty)

endmodule

`default_nettype wire

// ----- src/rw_queue_addr_map_hazard_top.sv -----
// memory controller front end: read and write queues with hazard check and address split
//
// input stream s_axis: tuser selects the request kind (0 add, 1 dispatch), tdata carries
// the read and write offers and the two downstream take flags. an add request queues the
// read unless the read queue is full or the write queue holds its address, then queues the
// write unless the write queue is full or the read queue (including that read) holds its
// address, and answers with one status result. a dispatch request pops each non-empty head
// that downstream takes and answers with zero, one or two results, read first, each with
// the address split into rank, row, bank, bank group and column; tlast marks the final one.
// latency: results appear on m_axis the cycle after the request is accepted.
// throughput: one add per cycle while results drain without stall; a dispatch that pops both
// heads holds s_axis_tready low while the two-entry result buffer holds both results.
// each queue is a row of eight slots that shift toward the head on pop; the address compare
// runs across all occupied slots in parallel.
// reset empties both queues and the result buffer; no clearing pass is needed.
// when m_axis stalls, buffered results hold and s_axis_tready stays low.
`default_nettype none
`include "rw_queue_addr_map_hazard_top_macros.svh"

module rw_queue_addr_map_hazard_top
    import rwq_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // rd_valid, rd_addr, rd_token, rd_to_cache, wr_valid, wr_addr, wr_token, wr_to_cache,
    // rd_taken, wr_taken
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // read_accepted, write_accepted, out_token, out_to_cache, out_rank, out_row, out_bank,
    // out_group, out_column, all_empty
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // kind
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tlast
);

    t_in_data  w_in;
    t_req      w_req;
    logic      w_accept;
    logic      w_out_take;

    t_cell_ctl w_rq_ctl, w_wq_ctl;
    t_entry    w_rq_new, w_wq_new, w_rq_head, w_wq_head;
    logic      w_rq_empty, w_rq_full, w_rq_one, w_rq_match;
    logic      w_wq_empty, w_wq_full, w_wq_one, w_wq_match;

    logic      w_rd_acc, w_wr_acc, w_rd_pop, w_wr_pop;
    logic      w_all_empty;
    t_result   w_res0, w_res1;
    t_out_data w_status;
    logic [1:0] w_new_cnt;

    t_result   r_res [2];
    logic [1:0] r_cnt;
    t_result   n_res [2];
    logic [1:0] n_cnt;

    assign w_in       = t_in_data'(s_axis_tdata[IN_BITS-1:0]);
    assign w_req      = t_req'(s_axis_tuser);
    assign w_out_take = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    // hazard check: the write also sees the read queued by the same request
    assign w_rd_acc = (w_req == REQ_ADD) && w_in.rd_valid && !w_rq_full && !w_wq_match;
    assign w_wr_acc = (w_req == REQ_ADD) && w_in.wr_valid && !w_wq_full
                      && !w_rq_match && !(w_rd_acc && (w_in.rd_addr == w_in.wr_addr));
    assign w_rd_pop = (w_req == REQ_DISPATCH) && w_in.rd_taken && !w_rq_empty;
    assign w_wr_pop = (w_req == REQ_DISPATCH) && w_in.wr_taken && !w_wq_empty;

    assign w_rq_new = '{addr: w_in.rd_addr, tag: w_in.rd_token, to_cache: w_in.rd_to_cache};
    assign w_wq_new = '{addr: w_in.wr_addr, tag: w_in.wr_token, to_cache: w_in.wr_to_cache};
    assign w_rq_ctl = '{push: w_accept && w_rd_acc, pop: w_accept && w_rd_pop};
    assign w_wq_ctl = '{push: w_accept && w_wr_acc, pop: w_accept && w_wr_pop};

    rwq_queue u_rd_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_rq_ctl),
        .i_new      (w_rq_new),
        .i_cmp_addr (w_in.wr_addr),
        .o_head     (w_rq_head),
        .o_empty    (w_rq_empty),
        .o_full     (w_rq_full),
        .o_one      (w_rq_one),
        .o_match    (w_rq_match)
    );

    rwq_queue u_wr_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_wq_ctl),
        .i_new      (w_wq_new),
        .i_cmp_addr (w_in.rd_addr),
        .o_head     (w_wq_head),
        .o_empty    (w_wq_empty),
        .o_full     (w_wq_full),
        .o_one      (w_wq_one),
        .o_match    (w_wq_match)
    );

    // occupancy after this request
    assign w_all_empty = (w_rq_empty || (w_rd_pop && w_rq_one)) && !w_rd_acc
                      && (w_wq_empty || (w_wr_pop && w_wq_one)) && !w_wr_acc;

    always_comb begin
        w_status                = '0;
        w_status.read_accepted  = w_rd_acc;
        w_status.write_accepted = w_wr_acc;
        w_status.all_empty      = w_all_empty;

        w_res0 = '0;
        w_res1 = '0;
        w_new_cnt = 2'd0;
        unique case (w_req)
            REQ_ADD: begin
                w_res0    = '{kind: KIND_STATUS, last: 1'b1, data: w_status};
                w_new_cnt = 2'd1;
            end
            REQ_DISPATCH: begin
                w_res1 = '{kind: KIND_WRITE, last: 1'b1, data: map_entry(w_wq_head)};
                w_res1.data.all_empty = w_all_empty;
                if (w_rd_pop) begin
                    w_res0 = '{kind: KIND_READ, last: !w_wr_pop, data: map_entry(w_rq_head)};
                end else begin
                    w_res0 = w_res1;
                end
                w_res0.data.all_empty = w_all_empty;
                w_new_cnt = {1'b0, w_rd_pop} + {1'b0, w_wr_pop};
            end
            default: begin
                w_new_cnt = 2'd0;
            end
        endcase
    end

    always_comb begin
        n_res = r_res;
        n_cnt = r_cnt;
        priority if (w_accept) begin
            n_res[0] = w_res0;
            n_res[1] = w_res1;
            n_cnt    = w_new_cnt;
        end else if (w_out_take) begin
            n_res[0] = r_res[1];
            n_cnt    = r_cnt - 2'd1;
        end else begin
            n_cnt    = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = OUT_TDATA_W'(r_res[0].data);
    assign m_axis_tuser  = r_res[0].kind;
    assign m_axis_tlast  = r_res[0].last;

    `RWQ_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `RWQ_ASSERT_NXT(a_add_status, i_clk, i_rst_n, w_accept && (w_req == REQ_ADD),
        m_axis_tvalid && (m_axis_tuser == KIND_STATUS) && m_axis_tlast)
    `RWQ_ASSERT_IMP(a_single_last, i_clk, i_rst_n, r_cnt == 2'd1, m_axis_tlast)

endmodule

`default_nettype wire
